/* rtl/core/labelled_block_downsample_3x3_assert.svh */
// Assertion macros used by the top-level RTL of the block downsampler.
`ifndef LABELLED_BLOCK_DOWNSAMPLE_3X3_ASSERT_SVH
`define LABELLED_BLOCK_DOWNSAMPLE_3X3_ASSERT_SVH

`ifndef SYNTHESIS
`define LBD3_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define LBD3_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define LBD3_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LBD3_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/lbd3_pkg.sv */
`default_nettype none

package lbd3_pkg;

   localparam int SUM_W     = 36;
   localparam int CNT_W     = 4;
   localparam int COORD_W   = 32;
   localparam int HEIGHT_W  = 32;
   localparam int GEOM_W    = 12;
   localparam int DIV_STEPS = SUM_W;

   localparam logic [1:0]        BLK_LAST_PHASE = 2'd2;
   localparam logic [1:0]        BLK_MID_PHASE  = 2'd1;
   localparam logic [CNT_W-1:0]  BLK_CELLS      = 4'd9;
   localparam logic [CNT_W-1:0]  THRESH_RESET   = 4'd5;
   localparam logic [GEOM_W-1:0] BLK_SIDE       = 12'd3;
   localparam logic [GEOM_W-1:0] ROWS_RESET     = 12'd4095;

   typedef enum logic [1:0] {
      CSR_COLS   = 2'd0,
      CSR_ROWS   = 2'd1,
      CSR_THRESH = 2'd2
   } csr_index_type;

   // One entry of the per-block-column accumulator memory.
   typedef struct packed {
      logic signed [SUM_W-1:0] bsum;
      logic signed [SUM_W-1:0] gsum;
      logic [CNT_W-1:0]        bcnt;
      logic [COORD_W-1:0]      cx;
      logic [COORD_W-1:0]      cy;
   } entry_type;

   typedef struct packed {
      logic                       first;
      logic                       centre;
      logic                       emit;
      logic                       last;
      logic                       building;
      logic signed [HEIGHT_W-1:0] height;
      logic [COORD_W-1:0]         xpos;
      logic [COORD_W-1:0]         ypos;
   } cmd_type;

   typedef struct packed {
      logic                    emit;
      logic                    isb;
      logic                    last;
      logic signed [SUM_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
      logic [COORD_W-1:0]      xpos;
      logic [COORD_W-1:0]      ypos;
   } blk_type;

endpackage

`default_nettype wire

/* rtl/core/lbd3_acc.sv */
`default_nettype none

module lbd3_acc
   import lbd3_pkg::*;
#(
   parameter int DEPTH = 682,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   input  wire logic [AW-1:0] cmd_idx,
   input  wire cmd_type       cmd,
   input  wire logic [3:0]    thresh,
   output logic               blk_valid,
   output blk_type            blk
);

   entry_type mem [DEPTH];

   entry_type       rd_ff;
   cmd_type         cmd_ff;
   logic [AW-1:0]   idx_ff;
   logic            vld_ff;
   entry_type       base;
   entry_type       wr_entry;
   logic signed [SUM_W-1:0] h_ext;
   logic            isb;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd_valid;
      end
   end

   // Read in the accept cycle, write back in the cycle after it; the control
   // never issues a new item before the write has landed.
   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         rd_ff  <= mem[cmd_idx];
         cmd_ff <= cmd;
         idx_ff <= cmd_idx;
      end
      if (vld_ff) begin
         mem[idx_ff] <= wr_entry;
      end
   end

   always_comb begin
      h_ext = {{(SUM_W - HEIGHT_W){cmd_ff.height[HEIGHT_W-1]}}, cmd_ff.height};
      base  = rd_ff;
      if (cmd_ff.first) begin
         base.bsum = '0;
         base.gsum = '0;
         base.bcnt = '0;
      end
      wr_entry = base;
      if (cmd_ff.building) begin
         wr_entry.bsum = base.bsum + h_ext;
         wr_entry.bcnt = base.bcnt + 4'd1;
      end else begin
         wr_entry.gsum = base.gsum + h_ext;
      end
      if (cmd_ff.centre) begin
         wr_entry.cx = cmd_ff.xpos;
         wr_entry.cy = cmd_ff.ypos;
      end
      isb = (wr_entry.bcnt >= thresh);
      blk.emit     = cmd_ff.emit;
      blk.isb      = isb;
      blk.last     = cmd_ff.last;
      blk.dividend = isb ? wr_entry.bsum : wr_entry.gsum;
      blk.divisor  = isb ? wr_entry.bcnt : (BLK_CELLS - wr_entry.bcnt);
      blk.xpos     = wr_entry.cx;
      blk.ypos     = wr_entry.cy;
   end

   assign blk_valid = vld_ff;

endmodule

`default_nettype wire

/* rtl/core/lbd3_div.sv */
`default_nettype none

module lbd3_div
   import lbd3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0]        divisor,
   output logic                         done,
   output logic [HEIGHT_W-1:0]          quotient
);

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SUM_W-1:0]    q_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    dvs_ff;
   logic                neg_ff;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;
   logic                ge;
   logic [SUM_W-1:0]    mag;
   logic [SUM_W-1:0]    q_signed;

   assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign trial = {rem_ff, q_ff[SUM_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   // Restoring division of the magnitude, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIV_STEPS);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= mag;
         rem_ff <= '0;
         dvs_ff <= divisor;
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         q_ff   <= {q_ff[SUM_W-2:0], ge};
         rem_ff <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign q_signed = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign quotient = q_signed[HEIGHT_W-1:0];
   assign done     = done_ff;

endmodule

`default_nettype wire

/* rtl/core/labelled_block_downsample_3x3.sv */
// The bottom-right cell of a 3x3 block is read, written back with its block sums, divided
// bit-serially over its 36-bit dividend and its result word loaded once the output register
// is free. A cell outside any complete block does not hold off the next; other cells hold
// off input until their write back, the bottom-right cell until its result word is loaded.
// Reset (synchronous, active high) restores the control and configuration registers to their
// defaults and restarts the frame; each block row overwrites the uncleared accumulator memory.
`default_nettype none

`include "labelled_block_downsample_3x3_assert.svh"

module labelled_block_downsample_3x3
   import lbd3_pkg::*;
#(
   parameter int MAX_COLS = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // in_height, in_xpos, in_ypos
   input  wire logic        req_tuser,  // in_building
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // out_height, out_xpos, out_ypos
   output logic             rsp_tuser,  // out_building
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   localparam int COLS_CAP_I = (MAX_COLS > 4095) ? 4095 : MAX_COLS;
   localparam logic [GEOM_W-1:0] COLS_CAP = GEOM_W'(COLS_CAP_I);
   localparam int NBLK  = COLS_CAP_I / 3;
   localparam int BC_W  = (NBLK > 1) ? $clog2(NBLK) : 1;
   localparam int BCC_W = $clog2(NBLK + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_OUT} state_type;

   state_type           state_ff;
   logic [GEOM_W-1:0]   cols_ff;
   logic [GEOM_W-1:0]   rows_ff;
   logic [3:0]          thresh_ff;
   logic [GEOM_W-1:0]   col_ff, col_in;
   logic [GEOM_W-1:0]   row_ff, row_in;
   logic [1:0]          pc_ff, pc_in;
   logic [1:0]          pr_ff, pr_in;
   logic [BCC_W-1:0]    bc_ff, bc_in;

   logic [GEOM_W-1:0]   cols_eff, rows_eff;
   logic [3:0]          thresh_eff;
   logic [GEOM_W:0]     col_end, row_end;
   logic                in_range;
   logic                req_fire;
   logic                geom_write;
   cmd_type             cmd;
   logic                cmd_valid;
   logic                blk_valid;
   blk_type             blk;
   logic                div_start;
   logic                div_done;
   logic [HEIGHT_W-1:0] quotient;
   logic                out_load;

   logic                rsp_tvalid_ff;
   logic [95:0]         rsp_tdata_ff;
   logic                rsp_tuser_ff;
   logic                rsp_tlast_ff;
   logic                pend_isb_ff;
   logic                pend_last_ff;
   logic [COORD_W-1:0]  pend_x_ff;
   logic [COORD_W-1:0]  pend_y_ff;

   assign csr_ready  = 1'b1;
   assign geom_write = csr_valid && csr_ready &&
                       (csr_index == CSR_COLS || csr_index == CSR_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= 12'd2048;
         rows_ff   <= ROWS_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLS:   cols_ff   <= csr_data;
            CSR_ROWS:   rows_ff   <= csr_data;
            CSR_THRESH: thresh_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff < BLK_SIDE) begin
         cols_eff = BLK_SIDE;
      end else if (cols_ff > COLS_CAP) begin
         cols_eff = COLS_CAP;
      end else begin
         cols_eff = cols_ff;
      end
      rows_eff = (rows_ff < BLK_SIDE) ? BLK_SIDE : rows_ff;
      if (thresh_ff == 4'd0) begin
         thresh_eff = 4'd1;
      end else if (thresh_ff > BLK_CELLS) begin
         thresh_eff = BLK_CELLS;
      end else begin
         thresh_eff = thresh_ff;
      end
   end

   // A cell counts only if its whole block lies inside the frame.
   assign col_end  = {1'b0, col_ff} - {11'd0, pc_ff} + 13'd2;
   assign row_end  = {1'b0, row_ff} - {11'd0, pr_ff} + 13'd2;
   assign in_range = (col_end < {1'b0, cols_eff}) && (row_end < {1'b0, rows_eff});

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      pc_in  = pc_ff;
      pr_in  = pr_ff;
      bc_in  = bc_ff;
      if (({1'b0, col_ff} + 13'd1) >= {1'b0, cols_eff}) begin
         col_in = '0;
         pc_in  = '0;
         bc_in  = '0;
         if (({1'b0, row_ff} + 13'd1) >= {1'b0, rows_eff}) begin
            row_in = '0;
            pr_in  = '0;
         end else begin
            row_in = row_ff + 1'b1;
            pr_in  = (pr_ff == BLK_LAST_PHASE) ? 2'd0 : pr_ff + 2'd1;
         end
      end else begin
         col_in = col_ff + 1'b1;
         if (pc_ff == BLK_LAST_PHASE) begin
            pc_in = '0;
            bc_in = bc_ff + 1'b1;
         end else begin
            pc_in = pc_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         col_ff <= '0;
         row_ff <= '0;
         pc_ff  <= '0;
         pr_ff  <= '0;
         bc_ff  <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
         pc_ff  <= pc_in;
         pr_ff  <= pr_in;
         bc_ff  <= bc_in;
      end
   end

   always_comb begin
      cmd.first    = (pr_ff == 2'd0) && (pc_ff == 2'd0);
      cmd.centre   = (pr_ff == BLK_MID_PHASE) && (pc_ff == BLK_MID_PHASE);
      cmd.emit     = (pr_ff == BLK_LAST_PHASE) && (pc_ff == BLK_LAST_PHASE);
      cmd.last     = (({1'b0, col_ff} + 13'd3) >= {1'b0, cols_eff}) &&
                     (({1'b0, row_ff} + 13'd3) >= {1'b0, rows_eff});
      cmd.building = req_tuser;
      cmd.height   = req_tdata[31:0];
      cmd.xpos     = req_tdata[63:32];
      cmd.ypos     = req_tdata[95:64];
   end

   assign cmd_valid = req_fire && in_range;

   lbd3_acc #(
      .DEPTH (NBLK)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_idx   (bc_ff[BC_W-1:0]),
      .cmd       (cmd),
      .thresh    (thresh_eff),
      .blk_valid (blk_valid),
      .blk       (blk)
   );

   assign div_start = (state_ff == ST_ACC) && blk_valid && blk.emit;

   lbd3_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (blk.dividend),
      .divisor  (blk.divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (cmd_valid) state_ff <= ST_ACC;
            ST_ACC: begin
               if (blk_valid) state_ff <= blk.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: if (div_done) state_ff <= ST_OUT;
            ST_OUT: if (out_load) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
      if (div_start) begin
         pend_isb_ff  <= blk.isb;
         pend_last_ff <= blk.last;
         pend_x_ff    <= blk.xpos;
         pend_y_ff    <= blk.ypos;
      end
      if (out_load) begin
         rsp_tdata_ff <= {pend_y_ff, pend_x_ff, quotient};
         rsp_tuser_ff <= pend_isb_ff;
         rsp_tlast_ff <= pend_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `LBD3_ASSERT_SAME(a_no_accept_during_rmw, clock, reset, blk_valid, !req_tready)
   `LBD3_ASSERT_SAME(a_divisor_nonzero, clock, reset, div_start, blk.divisor != 4'd0)
   `LBD3_ASSERT_NEXT(a_geom_restart, clock, reset, geom_write, col_ff == '0 && row_ff == '0)

endmodule

`default_nettype wire

/* dv/tb.sv */
module tb;
   import lbd3_pkg::*;

   localparam int COLS_MAX      = 2048;
   localparam int BLOCK_COLS    = COLS_MAX / 3;
   localparam int SETTLE_CYCLES = 50;
   localparam int STALL_LIMIT   = 2000;
   localparam int NUM_PHASES    = 9;

   // Geometry and threshold of each random phase, with the number of cells fed in it.
   localparam int PH_COLS   [NUM_PHASES] = '{3, 7, 11, 2, 9, 14, 4095, 5, 12};
   localparam int PH_ROWS   [NUM_PHASES] = '{3, 5, 4095, 2, 6, 7, 3, 0, 9};
   localparam int PH_THRESH [NUM_PHASES] = '{0, 9, 15, 5, 1, 3, 7, 4, 6};
   localparam int PH_ITEMS  [NUM_PHASES] = '{180, 210, 200, 180, 220, 200, 180, 200, 250};

   typedef struct packed {
      logic signed [31:0] height;
      logic               building;
      logic [31:0]        xpos;
      logic [31:0]        ypos;
   } grid_cell_type;

   typedef struct packed {
      logic signed [31:0] height;
      logic               building;
      logic [31:0]        xpos;
      logic [31:0]        ypos;
      logic               last;
   } block_type;

   typedef struct packed {
      grid_cell_type px;
      logic          typed;
      block_type     want;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [95:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [1:0]  csr_index  = CSR_COLS;
   logic [11:0] csr_data   = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_ready;

   labelled_block_downsample_3x3 #(
      .MAX_COLS(COLS_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Three single-block frames: all building at the top height, all ground at the bottom
   // height, and a 4-of-9 block whose ground mean of -2/5 must truncate to zero.
   dir_row_type dir_rows [27] = '{
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 32'h80000000}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h7FFFFFFF, 1'b1, 32'h0, 32'h0}, 1'b1,
        '{32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b1}},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'h80000000, 32'h7FFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
        '{32'h80000000, 1'b0, 32'h80000000, 32'h7FFFFFFF, 1'b1}},
      '{'{32'd100, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'd100, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'hFFFFFFFF, 1'b0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'd100, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'hFFFFFFFF, 1'b0, 32'h1, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{32'd100, 1'b1, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h0, 1'b0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h0, 1'b0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h0, 1'b0, 32'h0, 32'h0}, 1'b1, '{32'h0, 1'b0, 32'h1, 32'hFFFFFFFF, 1'b1}}
   };

   // Block downsampler state, one entry per block column.
   int unsigned cfg_cols   = COLS_MAX;
   int unsigned cfg_rows   = ROWS_RESET;
   int unsigned cfg_thresh = THRESH_RESET;
   longint      bld_sum [BLOCK_COLS] = '{default: 0};
   longint      gnd_sum [BLOCK_COLS] = '{default: 0};
   int unsigned bld_cnt [BLOCK_COLS] = '{default: 0};
   logic [31:0] mid_x   [BLOCK_COLS] = '{default: 0};
   logic [31:0] mid_y   [BLOCK_COLS] = '{default: 0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   block_type pending[$];
   int        errors   = 0;
   int        snd_idle = 0;
   int        rcv_idle = 0;
   int        quiet    = 0;

   function automatic bit fold_cell(input grid_cell_type c, output block_type r);
      int unsigned cols, rows, thr, bc, br, pc, pr, nbc, nbr, cnt;
      bit made;
      cols = (cfg_cols < 3) ? 3 : (cfg_cols > COLS_MAX) ? COLS_MAX : cfg_cols;
      rows = (cfg_rows < 3) ? 3 : cfg_rows;
      thr  = (cfg_thresh < 1) ? 1 : (cfg_thresh > 9) ? 9 : cfg_thresh;
      bc   = col_pos / 3;
      br   = row_pos / 3;
      pc   = col_pos % 3;
      pr   = row_pos % 3;
      nbc  = cols / 3;
      nbr  = rows / 3;
      made = 1'b0;
      r    = '0;
      if (bc < nbc && br < nbr) begin
         if (pr == 0 && pc == 0) begin
            bld_sum[bc] = 0;
            gnd_sum[bc] = 0;
            bld_cnt[bc] = 0;
         end
         if (c.building) begin
            bld_sum[bc] += longint'(c.height);
            bld_cnt[bc] += 1;
         end else begin
            gnd_sum[bc] += longint'(c.height);
         end
         if (pr == 1 && pc == 1) begin
            mid_x[bc] = c.xpos;
            mid_y[bc] = c.ypos;
         end
         if (pr == 2 && pc == 2) begin
            cnt        = bld_cnt[bc];
            r.building = (cnt >= thr);
            if (r.building) begin
               r.height = 32'(bld_sum[bc] / longint'(cnt));
            end else begin
               r.height = 32'(gnd_sum[bc] / longint'(9 - cnt));
            end
            r.xpos = mid_x[bc];
            r.ypos = mid_y[bc];
            r.last = (bc == nbc - 1 && br == nbr - 1);
            made   = 1'b1;
         end
      end
      if (col_pos + 1 >= cols) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return made;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COLS: begin
            cfg_cols = 32'(value);
            col_pos  = 0;
            row_pos  = 0;
         end
         CSR_ROWS: begin
            cfg_rows = 32'(value);
            col_pos  = 0;
            row_pos  = 0;
         end
         CSR_THRESH: cfg_thresh = 32'(value[3:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A typed expectation replaces the predicted one; the state is updated either way.
   task automatic send_cell(input grid_cell_type c, input bit typed, input block_type want);
      block_type got;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.ypos, c.xpos, c.height};
      req_tuser  <= c.building;
      do @(posedge clock); while (!req_tready);
      if (fold_cell(c, got)) begin
         pending.push_back(typed ? want : got);
      end
   endtask

   // Cells that give no word may still be in flight after the last word, hence the settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      block_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tuser, rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast};
            if (pending.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = pending.pop_front();
               if (got.height !== want.height) begin
                  $display("%0t: height expected %h actual %h", $time, want.height, got.height);
                  errors++;
               end
               if (got.building !== want.building) begin
                  $display("%0t: building expected %b actual %b", $time, want.building,
                           got.building);
                  errors++;
               end
               if (got.xpos !== want.xpos) begin
                  $display("%0t: xpos expected %h actual %h", $time, want.xpos, got.xpos);
                  errors++;
               end
               if (got.ypos !== want.ypos) begin
                  $display("%0t: ypos expected %h actual %h", $time, want.ypos, got.ypos);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet <= 0;
         end else begin
            quiet <= quiet + 1;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      grid_cell_type c;
      int unsigned bias;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      snd_idle = 8;
      rcv_idle = 79;
      @(posedge clock);

      // Geometry below range on both axes clamps to a single 3x3 block per frame.
      write_csr(CSR_COLS, 12'd0);
      write_csr(CSR_ROWS, 12'd1);
      foreach (dir_rows[i]) begin
         send_cell(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end

      bias = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 3) begin
            snd_idle = 79;
            rcv_idle = 8;
         end else if (p == 6) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         drain();
         write_csr(CSR_COLS, 12'(PH_COLS[p]));
         write_csr(CSR_ROWS, 12'(PH_ROWS[p]));
         write_csr(CSR_THRESH, 12'(PH_THRESH[p]));
         for (int i = 0; i < PH_ITEMS[p]; i++) begin
            // Hold the stream off mid-phase until every word has drained.
            if (i == PH_ITEMS[p] / 2) begin
               drain();
            end
            if (i % 9 == 0) begin
               bias = $urandom_range(0, 9);
            end
            c.building = ($urandom_range(0, 8) < bias);
            case ($urandom_range(0, 7))
               0:       c.height = 32'h7FFFFFFF;
               1:       c.height = 32'h80000000;
               2, 3:    c.height = 32'($urandom_range(0, 600)) - 32'd300;
               default: c.height = $urandom;
            endcase
            c.xpos = $urandom;
            c.ypos = $urandom;
            send_cell(c, 1'b0, '0);
         end
      end

      drain();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lbd3_pkg.sv
rtl/core/lbd3_acc.sv
rtl/core/lbd3_div.sv
rtl/core/labelled_block_downsample_3x3.sv
dv/tb.sv
